// File: hdl/lprl_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lprl_pkg
// Shared types and codes of the longest prefix match route lookup unit.
// ----------------------------------------------------------------------------
package lprl_pkg;

   localparam logic CMD_WRITE  = 1'b0;
   localparam logic CMD_LOOKUP = 1'b1;

   typedef struct packed {
      logic        cmd;
      logic [3:0]  entry_index;
      logic [31:0] dest_net;
      logic [31:0] net_mask;
      logic        entry_valid;
      logic [31:0] lookup_addr;
   } req_type;

   typedef struct packed {
      logic        found;
      logic [3:0]  match_index;
      logic [31:0] match_mask;
   } rsp_type;

   typedef struct packed {
      logic [31:0] dest;
      logic [31:0] mask;
   } route_type;

endpackage : lprl_pkg
`default_nettype wire

// File: hdl/lprl_route_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lprl_route_ram
// Route table store: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module lprl_route_ram
   import lprl_pkg::*;
#(
   parameter int DEPTH  = 16,
   parameter int ADDR_W = 4
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire route_type         wr_data,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output route_type              rd_data
);

   route_type mem [DEPTH];
   route_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule : lprl_route_ram
`default_nettype wire

// File: hdl/longest_prefix_route_lookup_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// longest_prefix_route_lookup_unit
// Longest prefix match over an indexed route table held in a synchronous RAM.
// ----------------------------------------------------------------------------
// A write request fills one table slot and leaves busy low, so writes may be
// issued back to back; a slot number at or beyond TABLE_ENTRIES is dropped. A
// lookup request scans the RAM one slot per cycle through its single read
// port: busy stays high through the scan and the drain of the last read, and
// the result is shown with rsp_strobe in the cycle that follows. A new request
// may be given in that result cycle. The result stands for that one cycle only
// and cannot be held off. Valid bits clear at reset; no clearing pass is
// needed.
// ----------------------------------------------------------------------------
module longest_prefix_route_lookup_unit
   import lprl_pkg::*;
#(
   parameter int TABLE_ENTRIES = 16
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    start,
   output logic         busy,
   input  wire req_type req_data,
   output logic         rsp_strobe,
   output rsp_type      rsp_data
);

   localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

   typedef enum logic [3:0] {
      ST_IDLE  = 4'b0001,
      ST_SCAN  = 4'b0010,
      ST_DRAIN = 4'b0100,
      ST_REPLY = 4'b1000
   } state_type;

   state_type                state_ff, state_in;
   logic [IDX_W-1:0]         scan_ff, scan_in;
   logic [TABLE_ENTRIES-1:0] valid_ff;
   logic                     pend_ff;
   logic [IDX_W-1:0]         pend_idx_ff;
   logic [31:0]              addr_ff;
   logic                     best_hit_ff;
   logic [IDX_W-1:0]         best_idx_ff;
   logic [31:0]              best_mask_ff;

   logic                     accept;
   logic                     wr_req;
   logic                     lookup_req;
   logic                     wr_in_range;
   logic [IDX_W-1:0]         wr_idx;
   logic                     scan_last;
   logic                     match;
   route_type                rd_entry;
   route_type                wr_entry;

   assign accept      = start && !busy;
   assign wr_req      = accept && (req_data.cmd == CMD_WRITE);
   assign lookup_req  = accept && (req_data.cmd == CMD_LOOKUP);
   assign wr_in_range = 32'(req_data.entry_index) < 32'(TABLE_ENTRIES);
   assign wr_idx      = IDX_W'(req_data.entry_index);
   assign scan_last   = scan_ff == IDX_W'(TABLE_ENTRIES - 1);
   assign wr_entry    = '{dest: req_data.dest_net, mask: req_data.net_mask};

   lprl_route_ram #(
      .DEPTH  (TABLE_ENTRIES),
      .ADDR_W (IDX_W)
   ) u_route_ram (
      .clock   (clock),
      .wr_en   (wr_req && wr_in_range),
      .wr_addr (wr_idx),
      .wr_data (wr_entry),
      .rd_addr (scan_ff),
      .rd_data (rd_entry)
   );

   assign match = pend_ff
      && (((addr_ff ^ rd_entry.dest) & rd_entry.mask) == 32'd0)
      && (rd_entry.mask >= best_mask_ff);

   always_comb begin
      state_in = state_ff;
      scan_in  = scan_ff;
      unique case (state_ff)
         ST_IDLE, ST_REPLY: begin
            state_in = lookup_req ? ST_SCAN : ST_IDLE;
            scan_in  = '0;
         end
         ST_SCAN: begin
            if (scan_last) begin
               state_in = ST_DRAIN;
            end else begin
               scan_in = scan_ff + IDX_W'(1);
            end
         end
         ST_DRAIN: begin
            state_in = ST_REPLY;
         end
         default: begin
            state_in = ST_IDLE;
            scan_in  = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         scan_ff     <= '0;
         valid_ff    <= '0;
         pend_ff     <= 1'b0;
         best_hit_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         scan_ff  <= scan_in;
         pend_ff  <= (state_ff == ST_SCAN) && valid_ff[scan_ff];
         if (wr_req && wr_in_range) begin
            valid_ff[wr_idx] <= req_data.entry_valid;
         end
         if (lookup_req) begin
            best_hit_ff <= 1'b0;
         end else if (match) begin
            best_hit_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      pend_idx_ff <= scan_ff;
      if (lookup_req) begin
         addr_ff      <= req_data.lookup_addr;
         best_idx_ff  <= '0;
         best_mask_ff <= '0;
      end else if (match) begin
         best_idx_ff  <= pend_idx_ff;
         best_mask_ff <= rd_entry.mask;
      end
   end

   assign busy       = (state_ff == ST_SCAN) || (state_ff == ST_DRAIN);
   assign rsp_strobe = state_ff == ST_REPLY;

   always_comb begin
      rsp_data.found       = best_hit_ff;
      rsp_data.match_index = best_hit_ff ? 4'(best_idx_ff) : 4'd0;
      rsp_data.match_mask  = best_hit_ff ? best_mask_ff : 32'd0;
   end

   a_single_strobe : assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !$past(rsp_strobe))
      else $error("result strobe held for more than one cycle");

   a_miss_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_data.found) |->
         (rsp_data.match_index == 4'd0 && rsp_data.match_mask == 32'd0))
      else $error("miss reported with non-zero index or mask");

   a_lookup_busy : assert property (@(posedge clock) disable iff (reset)
      lookup_req |=> busy && !rsp_strobe)
      else $error("lookup request did not start a scan");

   a_write_silent : assert property (@(posedge clock) disable iff (reset)
      (wr_req && state_ff == ST_IDLE) |=> !rsp_strobe && !busy)
      else $error("write request produced a result or stalled");

endmodule : longest_prefix_route_lookup_unit
`default_nettype wire

// File: tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the longest prefix match route lookup unit.
// ----------------------------------------------------------------------------
// Table writes and address lookups are queued up front: first a directed set
// that fills every slot, then checks removal, default routes, equal masks and
// full-length masks; after that a random mix biased towards addresses that hit
// a live route. A clocked driver issues each request after a random gap and
// keeps a shadow route table that predicts every lookup result at acceptance.
// A clocked monitor compares each strobed result with the oldest prediction.
// ----------------------------------------------------------------------------
module testbench
   import lprl_pkg::*;
;

   localparam int TABLE_ENTRIES = 16;
   localparam int RANDOM_REQUESTS = 1550;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   req_type req_data = '0;
   logic    busy;
   logic    rsp_strobe;
   rsp_type rsp_data;

   longest_prefix_route_lookup_unit #(
      .TABLE_ENTRIES(TABLE_ENTRIES)
   ) uut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_strobe(rsp_strobe),
      .rsp_data  (rsp_data)
   );

   req_type     route_requests [$];
   rsp_type     lookup_results_due [$];
   int          mismatch_count = 0;
   int          req_gap = 0;
   logic        no_idle = 1'b0;

   logic [31:0] shadow_dest [TABLE_ENTRIES];
   logic [31:0] shadow_mask [TABLE_ENTRIES];
   logic        shadow_valid [TABLE_ENTRIES] = '{default: 1'b0};

   logic [31:0] plan_dest [TABLE_ENTRIES];
   logic [31:0] plan_mask [TABLE_ENTRIES];
   logic        plan_valid [TABLE_ENTRIES] = '{default: 1'b0};

   rsp_type     rsp_due;

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic logic [31:0] prefix_mask(input int len);
      if (len <= 0)
         return 32'h0;
      return 32'hFFFF_FFFF << (32 - len);
   endfunction

   task automatic push_write(input logic [3:0] idx, input logic [31:0] dest,
                             input logic [31:0] mask, input logic valid);
      req_type r;
      r.cmd         = CMD_WRITE;
      r.entry_index = idx;
      r.dest_net    = dest;
      r.net_mask    = mask;
      r.entry_valid = valid;
      r.lookup_addr = $urandom;
      route_requests.push_back(r);
      if (idx < TABLE_ENTRIES) begin
         plan_dest[idx]  = dest;
         plan_mask[idx]  = mask;
         plan_valid[idx] = valid;
      end
   endtask

   task automatic push_lookup(input logic [31:0] addr);
      req_type r;
      r.cmd         = CMD_LOOKUP;
      r.entry_index = 4'($urandom_range(0, 15));
      r.dest_net    = $urandom;
      r.net_mask    = $urandom;
      r.entry_valid = 1'($urandom_range(0, 1));
      r.lookup_addr = addr;
      route_requests.push_back(r);
   endtask

   task automatic apply_route_request(input req_type r);
      rsp_type     res;
      logic [31:0] best;
      res  = '0;
      best = '0;
      if (r.cmd == CMD_WRITE) begin
         if (r.entry_index < TABLE_ENTRIES) begin
            shadow_dest[r.entry_index]  = r.dest_net;
            shadow_mask[r.entry_index]  = r.net_mask;
            shadow_valid[r.entry_index] = r.entry_valid;
         end
      end else begin
         for (int i = 0; i < TABLE_ENTRIES; i++) begin
            if (shadow_valid[i] &&
                ((r.lookup_addr & shadow_mask[i]) == (shadow_dest[i] & shadow_mask[i])) &&
                shadow_mask[i] >= best) begin
               best            = shadow_mask[i];
               res.found       = 1'b1;
               res.match_index = 4'(i);
               res.match_mask  = shadow_mask[i];
            end
         end
         lookup_results_due.push_back(res);
      end
   endtask

   task automatic draw_gap();
      if ($urandom_range(0, 63) == 0)
         no_idle <= !no_idle;
      req_gap <= no_idle ? 0 : $urandom_range(0, 16);
   endtask

   task automatic report_error(input string msg);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("%0t: %s", $realtime, msg);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         start   <= 1'b0;
         req_gap <= 0;
      end else if (start && !busy) begin
         apply_route_request(req_data);
         if (req_gap == 0 && route_requests.size() != 0) begin
            req_data <= route_requests.pop_front();
            draw_gap();
         end else begin
            start <= 1'b0;
         end
      end else if (!start && route_requests.size() != 0) begin
         if (req_gap != 0) begin
            req_gap <= req_gap - 1;
         end else begin
            start    <= 1'b1;
            req_data <= route_requests.pop_front();
            draw_gap();
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (lookup_results_due.size() == 0) begin
            report_error($sformatf("unexpected result found=%0b index=%0d mask=%08h",
                                   rsp_data.found, rsp_data.match_index,
                                   rsp_data.match_mask));
         end else begin
            rsp_due = lookup_results_due.pop_front();
            if (rsp_data.found !== rsp_due.found ||
                rsp_data.match_index !== rsp_due.match_index ||
                rsp_data.match_mask !== rsp_due.match_mask)
               report_error($sformatf(
                  {"result mismatch: expected found=%0b index=%0d mask=%08h,",
                   " got found=%0b index=%0d mask=%08h"},
                  rsp_due.found, rsp_due.match_index, rsp_due.match_mask,
                  rsp_data.found, rsp_data.match_index, rsp_data.match_mask));
         end
      end
   end

   initial begin
      int          live [$];
      int          slot;
      int          sel;
      int          drain;
      logic [31:0] addr;
      logic [31:0] mask;
      logic [31:0] dest;

      // fill every slot so no lookup scans an unwritten entry
      for (int i = 0; i < TABLE_ENTRIES; i++)
         push_write(4'(i), $urandom, $urandom, 1'b0);
      push_lookup(32'h0000_0000);
      push_write(4'd3, 32'h0000_0000, 32'h0000_0000, 1'b1);
      push_lookup(32'hFFFF_FFFF);
      push_write(4'd5, 32'hC0A8_0100, 32'hFFFF_FF00, 1'b1);
      push_write(4'd9, 32'hC0A8_0100, 32'hFFFF_FF00, 1'b1);
      push_lookup(32'hC0A8_01FF);
      push_write(4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
      push_lookup(32'hFFFF_FFFF);
      push_write(4'd9, 32'hC0A8_0100, 32'hFFFF_FF00, 1'b0);
      push_lookup(32'hC0A8_0123);
      push_write(4'd0, 32'h0000_0000, 32'h0000_0000, 1'b1);
      push_lookup(32'h1234_5678);
      push_write(4'd7, 32'h0000_FFFF, 32'h8000_FFFF, 1'b1);
      push_lookup(32'h7ABC_FFFF);
      push_lookup(32'hFFFF_FFFE);

      for (int n = 0; n < RANDOM_REQUESTS; n++) begin
         if ($urandom_range(0, 9) < 4) begin
            sel = $urandom_range(0, 9);
            if (sel == 0)
               mask = 32'h0;
            else if (sel == 1)
               mask = 32'hFFFF_FFFF;
            else if (sel == 2)
               mask = $urandom;
            else
               mask = prefix_mask($urandom_range(1, 31));
            if ($urandom_range(0, 3) == 0)
               dest = plan_dest[$urandom_range(0, TABLE_ENTRIES - 1)];
            else
               dest = $urandom;
            push_write(4'($urandom_range(0, 15)), dest, mask,
                       1'($urandom_range(0, 4) != 0));
         end else begin
            live.delete();
            for (int i = 0; i < TABLE_ENTRIES; i++)
               if (plan_valid[i])
                  live.push_back(i);
            sel = $urandom_range(0, 9);
            if (sel < 7 && live.size() != 0) begin
               slot = live[$urandom_range(0, live.size() - 1)];
               addr = (plan_dest[slot] & plan_mask[slot]) | ($urandom & ~plan_mask[slot]);
               if (sel == 6)
                  addr = addr ^ (32'h1 << $urandom_range(0, 31));
            end else begin
               addr = $urandom;
            end
            push_lookup(addr);
         end
      end

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      while (route_requests.size() != 0 || start)
         @(posedge clock);
      drain = 0;
      while (lookup_results_due.size() != 0 && drain < 1000) begin
         @(posedge clock);
         drain++;
      end
      repeat (TABLE_ENTRIES + 4) @(posedge clock);

      if (mismatch_count == 0 && lookup_results_due.size() == 0)
         $display("testbench OK");
      else
         $display("testbench NOT OK");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("testbench NOT OK");
      $finish;
   end

endmodule : testbench

// File: sim.f
hdl/lprl_pkg.sv
hdl/lprl_route_ram.sv
hdl/longest_prefix_route_lookup_unit.sv
tb/testbench.sv
